### rtl/core/gbn_pkg.sv
`timescale 1ns / 1ps
package gbn_pkg;

  localparam int unsigned GBN_MAX_BOXES = 64;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned CORNER_W      = 4 * COORD_W;
  localparam int unsigned ATTR_W        = 56;
  localparam int unsigned LIMIT_W       = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd29491;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;          // latch the last flag and load the pointer with the count
    logic store;         // write the request into the box stores
    logic ord_rd_prev;   // read order entry at pointer minus one
    logic ord_rd_cur;    // read order entry at pointer
    logic ord_wr_shift;  // move the entry just read to the pointer position
    logic ord_wr_new;    // place the new request at the pointer position
    logic ptr_dec;
    logic ptr_inc;
    logic ptr_clr;
    logic cnt_inc;
    logic cnt_clr;
    logic crn_rd;        // read candidate corners by the slot from the order store
    logic kidx_clr;
    logic kidx_inc;
    logic kept_rd;       // read kept entry at kidx; during suppression it also starts the overlap test
    logic kept_wr;       // append candidate to the kept list
    logic kept_clr;
    logic attr_rd;       // read attributes by the slot from the kept entry
    logic out_load;
  } gbn_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic ptr_zero;
    logic ptr_at_cnt;
    logic kidx_at_kept;
    logic ins_lower;
    logic last_set;
    logic iou_done;
    logic iou_supp;
    logic out_busy;
  } gbn_status_t;

endpackage

### rtl/core/gbn_ram.sv
`timescale 1ns / 1ps
module gbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/gbn_ctrl.sv
`timescale 1ns / 1ps
module gbn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_box_i,
  output logic                in_stall_o,
  input  gbn_pkg::gbn_status_t status_i,
  output gbn_pkg::gbn_cmd_t    cmd_o
);
  import gbn_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    INS_CHECK,
    INS_CMP,
    INS_PLACE,
    SUP_START,
    SUP_RD_ORD,
    SUP_RD_CRN,
    SUP_KRD,
    SUP_IOU,
    SUP_KEEP,
    EMIT_RD,
    EMIT_ATTR,
    EMIT_LOAD,
    EMIT_WAIT
  } state_e;

  state_e state_q, state_d;
  gbn_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd.take = 1'b1;
          if (!status_i.full) begin
            cmd.store = 1'b1;
            state_d   = INS_CHECK;
          end else if (last_box_i) begin
            state_d = SUP_START;
          end
        end
      end
      INS_CHECK: begin
        if (status_i.ptr_zero) begin
          state_d = INS_PLACE;
        end else begin
          cmd.ord_rd_prev = 1'b1;
          state_d         = INS_CMP;
        end
      end
      INS_CMP: begin
        if (status_i.ins_lower) begin
          cmd.ord_wr_shift = 1'b1;
          cmd.ptr_dec      = 1'b1;
          state_d          = INS_CHECK;
        end else begin
          state_d = INS_PLACE;
        end
      end
      INS_PLACE: begin
        cmd.ord_wr_new = 1'b1;
        cmd.cnt_inc    = 1'b1;
        state_d        = status_i.last_set ? SUP_START : IDLE;
      end
      SUP_START: begin
        cmd.ptr_clr  = 1'b1;
        cmd.kept_clr = 1'b1;
        state_d      = status_i.cnt_zero ? IDLE : SUP_RD_ORD;
      end
      SUP_RD_ORD: begin
        if (status_i.ptr_at_cnt) begin
          cmd.kidx_clr = 1'b1;
          state_d      = EMIT_RD;
        end else begin
          cmd.ord_rd_cur = 1'b1;
          state_d        = SUP_RD_CRN;
        end
      end
      SUP_RD_CRN: begin
        cmd.crn_rd   = 1'b1;
        cmd.kidx_clr = 1'b1;
        state_d      = SUP_KRD;
      end
      SUP_KRD: begin
        if (status_i.kidx_at_kept) begin
          state_d = SUP_KEEP;
        end else begin
          cmd.kept_rd = 1'b1;
          state_d     = SUP_IOU;
        end
      end
      SUP_IOU: begin
        if (status_i.iou_done) begin
          if (status_i.iou_supp) begin
            cmd.ptr_inc = 1'b1;
            state_d     = SUP_RD_ORD;
          end else begin
            cmd.kidx_inc = 1'b1;
            state_d      = SUP_KRD;
          end
        end
      end
      SUP_KEEP: begin
        cmd.kept_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_d     = SUP_RD_ORD;
      end
      EMIT_RD: begin
        if (status_i.kidx_at_kept) begin
          cmd.cnt_clr = 1'b1;
          state_d     = IDLE;
        end else begin
          cmd.kept_rd = 1'b1;
          state_d     = EMIT_ATTR;
        end
      end
      EMIT_ATTR: begin
        cmd.attr_rd = 1'b1;
        state_d     = EMIT_LOAD;
      end
      EMIT_LOAD: begin
        cmd.out_load = 1'b1;
        state_d      = EMIT_WAIT;
      end
      EMIT_WAIT: begin
        if (!status_i.out_busy) begin
          cmd.kidx_inc = 1'b1;
          state_d      = EMIT_RD;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != IDLE);

  // The overlap pipeline only reports while the controller waits for it.
  a_iou_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.iou_done |-> state_q == SUP_IOU)
    else $error("overlap result outside of the wait state");

  // A new result is never loaded over one that is still pending.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !status_i.out_busy)
    else $error("output register overwritten");

  // Once a set is closed, no request is taken until all results are out.
  a_stall_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == EMIT_WAIT |-> in_stall_o)
    else $error("input taken during emission");

endmodule

### rtl/core/gbn_dp.sv
`timescale 1ns / 1ps
module gbn_dp #(
  parameter int unsigned MAX_BOXES = gbn_pkg::GBN_MAX_BOXES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gbn_pkg::gbn_cmd_t                 cmd_i,
  output gbn_pkg::gbn_status_t              status_o,
  input  logic [gbn_pkg::LIMIT_W-1:0]       iou_limit_i,
  input  logic [15:0]                       x_min_i,
  input  logic [15:0]                       y_min_i,
  input  logic [15:0]                       x_max_i,
  input  logic [15:0]                       y_max_i,
  input  logic [15:0]                       score_i,
  input  logic [3:0]                        shape_class_i,
  input  logic [3:0]                        color_class_i,
  input  logic signed [15:0]                dir_sin_i,
  input  logic signed [15:0]                dir_cos_i,
  input  logic                              last_box_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [15:0]                       kept_x_min_o,
  output logic [15:0]                       kept_y_min_o,
  output logic [15:0]                       kept_x_max_o,
  output logic [15:0]                       kept_y_max_o,
  output logic [15:0]                       kept_score_o,
  output logic [3:0]                        kept_shape_o,
  output logic [3:0]                        kept_color_o,
  output logic signed [15:0]                kept_sin_o,
  output logic signed [15:0]                kept_cos_o,
  output logic                              last_kept_o
);
  import gbn_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int unsigned ORD_W  = IDX_W + COORD_W;
  localparam int unsigned KEPT_W = IDX_W + CORNER_W;

  logic [CNT_W-1:0]   cnt_q, ptr_q, kidx_q, kept_n_q;
  logic [COORD_W-1:0] new_score_q;
  logic [IDX_W-1:0]   new_slot_q;
  logic               last_q;

  logic [ORD_W-1:0]    ord_rdata, ord_wdata;
  logic [IDX_W-1:0]    ord_raddr;
  logic [CORNER_W-1:0] crn_rdata;
  logic [ATTR_W-1:0]   attr_rdata;
  logic [KEPT_W-1:0]   kept_rdata;
  logic [CNT_W-1:0]    ptr_m1;

  assign ptr_m1    = ptr_q - 1'b1;
  assign ord_raddr = cmd_i.ord_rd_prev ? ptr_m1[IDX_W-1:0] : ptr_q[IDX_W-1:0];
  assign ord_wdata = cmd_i.ord_wr_new ? {new_slot_q, new_score_q} : ord_rdata;

  gbn_ram #(.WIDTH(CORNER_W), .DEPTH(MAX_BOXES)) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({y_max_i, x_max_i, y_min_i, x_min_i}),
    .re_i    (cmd_i.crn_rd),
    .raddr_i (ord_rdata[ORD_W-1:COORD_W]),
    .rdata_o (crn_rdata)
  );

  gbn_ram #(.WIDTH(ATTR_W), .DEPTH(MAX_BOXES)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({dir_cos_i, dir_sin_i, color_class_i, shape_class_i, score_i}),
    .re_i    (cmd_i.attr_rd),
    .raddr_i (kept_rdata[KEPT_W-1:CORNER_W]),
    .rdata_o (attr_rdata)
  );

  gbn_ram #(.WIDTH(ORD_W), .DEPTH(MAX_BOXES)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ord_wr_shift | cmd_i.ord_wr_new),
    .waddr_i (ptr_q[IDX_W-1:0]),
    .wdata_i (ord_wdata),
    .re_i    (cmd_i.ord_rd_prev | cmd_i.ord_rd_cur),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  gbn_ram #(.WIDTH(KEPT_W), .DEPTH(MAX_BOXES)) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.kept_wr),
    .waddr_i (kept_n_q[IDX_W-1:0]),
    .wdata_i ({ord_rdata[ORD_W-1:COORD_W], crn_rdata}),
    .re_i    (cmd_i.kept_rd),
    .raddr_i (kidx_q[IDX_W-1:0]),
    .rdata_o (kept_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ptr_q    <= '0;
      kidx_q   <= '0;
      kept_n_q <= '0;
      last_q   <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.take) begin
        ptr_q  <= cnt_q;
        last_q <= last_box_i;
      end else if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_m1;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.kidx_clr) begin
        kidx_q <= '0;
      end else if (cmd_i.kidx_inc) begin
        kidx_q <= kidx_q + 1'b1;
      end
      if (cmd_i.kept_clr || cmd_i.cnt_clr) begin
        kept_n_q <= '0;
      end else if (cmd_i.kept_wr) begin
        kept_n_q <= kept_n_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      new_score_q <= score_i;
      new_slot_q  <= cnt_q[IDX_W-1:0];
    end
  end

  // Emission reads also use the kept store; they must not start the overlap test.
  logic last_emit_phase;
  logic emit_phase_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_phase_q <= 1'b0;
    end else if (cmd_i.kept_clr) begin
      emit_phase_q <= 1'b0;
    end else if (cmd_i.kidx_clr && (ptr_q == cnt_q)) begin
      emit_phase_q <= 1'b1;
    end else if (cmd_i.cnt_clr) begin
      emit_phase_q <= 1'b0;
    end
  end
  assign last_emit_phase = emit_phase_q;

  // Overlap test between the candidate corners and one kept entry.
  function automatic logic [COORD_W-1:0] extent(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  logic [CORNER_W-1:0] bc;
  logic [COORD_W-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic                v0_q, v1_q, v2_q, v3_q, v4_q;
  logic [COORD_W-1:0]  ox_q, oy_q, eax_q, eay_q, ebx_q, eby_q;
  logic [31:0]         inter2_q, aa_q, ab_q, inter3_q;
  logic [32:0]         uni_q;
  logic [47:0]         lhs_q;
  logic [49:0]         rhs_q;
  logic                uni_nz_q;

  assign bc   = kept_rdata[CORNER_W-1:0];
  assign lo_x = (crn_rdata[15:0]  > bc[15:0])  ? crn_rdata[15:0]  : bc[15:0];
  assign hi_x = (crn_rdata[47:32] < bc[47:32]) ? crn_rdata[47:32] : bc[47:32];
  assign lo_y = (crn_rdata[31:16] > bc[31:16]) ? crn_rdata[31:16] : bc[31:16];
  assign hi_y = (crn_rdata[63:48] < bc[63:48]) ? crn_rdata[63:48] : bc[63:48];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.kept_rd & ~cmd_i.attr_rd & (kidx_q != kept_n_q) & ~last_emit_phase;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q     <= extent(lo_x, hi_x);
    oy_q     <= extent(lo_y, hi_y);
    eax_q    <= extent(crn_rdata[15:0], crn_rdata[47:32]);
    eay_q    <= extent(crn_rdata[31:16], crn_rdata[63:48]);
    ebx_q    <= extent(bc[15:0], bc[47:32]);
    eby_q    <= extent(bc[31:16], bc[63:48]);
    inter2_q <= ox_q * oy_q;
    aa_q     <= eax_q * eay_q;
    ab_q     <= ebx_q * eby_q;
    uni_q    <= 33'(aa_q) + 33'(ab_q) - 33'(inter2_q);
    inter3_q <= inter2_q;
    lhs_q    <= {inter3_q, 16'h0000};
    rhs_q    <= 50'(iou_limit_i) * 50'(uni_q);
    uni_nz_q <= (uni_q != '0);
  end

  // Output register.
  logic out_valid_q, out_last_q;
  logic [CORNER_W-1:0] out_crn_q;
  logic [ATTR_W-1:0]   out_attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_crn_q  <= kept_rdata[CORNER_W-1:0];
      out_attr_q <= attr_rdata;
      out_last_q <= (kidx_q == kept_n_q - 1'b1);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kept_x_min_o = out_crn_q[15:0];
  assign kept_y_min_o = out_crn_q[31:16];
  assign kept_x_max_o = out_crn_q[47:32];
  assign kept_y_max_o = out_crn_q[63:48];
  assign kept_score_o = out_attr_q[15:0];
  assign kept_shape_o = out_attr_q[19:16];
  assign kept_color_o = out_attr_q[23:20];
  assign kept_sin_o   = out_attr_q[39:24];
  assign kept_cos_o   = out_attr_q[55:40];
  assign last_kept_o  = out_last_q;

  always_comb begin
    status_o.full         = (cnt_q == CNT_W'(MAX_BOXES));
    status_o.cnt_zero     = (cnt_q == '0);
    status_o.ptr_zero     = (ptr_q == '0);
    status_o.ptr_at_cnt   = (ptr_q == cnt_q);
    status_o.kidx_at_kept = (kidx_q == kept_n_q);
    status_o.ins_lower    = (ord_rdata[COORD_W-1:0] < new_score_q);
    status_o.last_set     = last_q;
    status_o.iou_done     = v4_q;
    status_o.iou_supp     = uni_nz_q && (50'(lhs_q) > rhs_q);
    status_o.out_busy     = out_valid_q;
  end

  a_kept_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_n_q <= cnt_q || cnt_q == '0)
    else $error("more kept boxes than stored boxes");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> cnt_q < CNT_W'(MAX_BOXES))
    else $error("store into a full set");

endmodule

### rtl/core/greedy_box_nms.sv
// Greedy box suppression: collects a set, sorts by score, keeps boxes by IoU, emits them.
// Each request is stored, then walks down the sorted order store past each stored box of
// lower score and is placed; the closing request then starts suppression and emission.
// Suppression tests each candidate against the kept boxes, stopping at one that suppresses it
// (read of the kept store and the four stage overlap pipeline); each result is held until taken.
// Reset (rst_ni low, asynchronous) empties the set and sets the IoU limit to 29491.
`timescale 1ns / 1ps
module greedy_box_nms #(
  parameter int unsigned MAX_BOXES = gbn_pkg::GBN_MAX_BOXES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gbn_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 x_min_i,
  input  logic [15:0]                 y_min_i,
  input  logic [15:0]                 x_max_i,
  input  logic [15:0]                 y_max_i,
  input  logic [15:0]                 score_i,
  input  logic [3:0]                  shape_class_i,
  input  logic [3:0]                  color_class_i,
  input  logic signed [15:0]          dir_sin_i,
  input  logic signed [15:0]          dir_cos_i,
  input  logic                        last_box_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [15:0]                 kept_x_min_o,
  output logic [15:0]                 kept_y_min_o,
  output logic [15:0]                 kept_x_max_o,
  output logic [15:0]                 kept_y_max_o,
  output logic [15:0]                 kept_score_o,
  output logic [3:0]                  kept_shape_o,
  output logic [3:0]                  kept_color_o,
  output logic signed [15:0]          kept_sin_o,
  output logic signed [15:0]          kept_cos_o,
  output logic                        last_kept_o
);
  import gbn_pkg::*;

  logic [LIMIT_W-1:0] iou_limit_q;
  gbn_cmd_t    cmd;
  gbn_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      iou_limit_q <= cfg_data_i;
    end
  end

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_box_i (last_box_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbn_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .iou_limit_i   (iou_limit_q),
    .x_min_i       (x_min_i),
    .y_min_i       (y_min_i),
    .x_max_i       (x_max_i),
    .y_max_i       (y_max_i),
    .score_i       (score_i),
    .shape_class_i (shape_class_i),
    .color_class_i (color_class_i),
    .dir_sin_i     (dir_sin_i),
    .dir_cos_i     (dir_cos_i),
    .last_box_i    (last_box_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kept_x_min_o  (kept_x_min_o),
    .kept_y_min_o  (kept_y_min_o),
    .kept_x_max_o  (kept_x_max_o),
    .kept_y_max_o  (kept_y_max_o),
    .kept_score_o  (kept_score_o),
    .kept_shape_o  (kept_shape_o),
    .kept_color_o  (kept_color_o),
    .kept_sin_o    (kept_sin_o),
    .kept_cos_o    (kept_cos_o),
    .last_kept_o   (last_kept_o)
  );

endmodule
